@@ rtl/position_to_pan_tilt_bytes_unit_assert.svh @@
// assertion macros shared by the pan/tilt aiming block
// expects clk and arst_n to be visible where a macro is used
`ifndef POSITION_TO_PAN_TILT_BYTES_UNIT_ASSERT_SVH
`define POSITION_TO_PAN_TILT_BYTES_UNIT_ASSERT_SVH

// antecedent holds in this cycle, consequent holds in the same cycle
`define PTTB_ASSERT_IMPL(name, ante, cons) \
	name: assert property (@(posedge clk) disable iff (!arst_n) (ante) |-> (cons)) \
		else $error("pttb assertion failed");

// antecedent holds in this cycle, consequent holds in the next cycle
`define PTTB_ASSERT_NEXT(name, ante, cons) \
	name: assert property (@(posedge clk) disable iff (!arst_n) (ante) |=> (cons)) \
		else $error("pttb assertion failed");

`endif

@@ rtl/pttb_pkg.sv @@
// shared constants, types and the arctangent table of the pan/tilt aiming block
// no dependencies
package pttb_pkg;

	localparam int COORD_WIDTH_DEF   = 24;
	localparam int CORDIC_STAGES_DEF = 16;
	localparam int ROOT_STEPS        = 32;
	localparam int ROOT_W            = 64;
	localparam int DP_W              = 60;
	localparam int ANG_W             = 34;
	localparam int PRE_SHIFT         = 24;

	localparam logic [31:0] LIGHT_HEIGHT_RST = 32'd158971;
	localparam logic signed [ANG_W-1:0] QUARTER_TURN = 34'sh0_4000_0000;

	typedef logic signed [DP_W-1:0]  dp_t;
	typedef logic signed [ANG_W-1:0] ang_t;

	typedef struct packed {
		dp_t  x;
		dp_t  y;
		ang_t ang;
	} vec_t;

	// atan(2^-i) in 2^-32 turn
	function automatic logic [31:0] atan_turn(input int idx);
		logic [31:0] v;
		case (idx)
			0:  v = 32'd536870912;
			1:  v = 32'd316933406;
			2:  v = 32'd167458907;
			3:  v = 32'd85004756;
			4:  v = 32'd42667331;
			5:  v = 32'd21354465;
			6:  v = 32'd10679838;
			7:  v = 32'd5340245;
			8:  v = 32'd2670163;
			9:  v = 32'd1335087;
			10: v = 32'd667544;
			11: v = 32'd333772;
			12: v = 32'd166886;
			13: v = 32'd83443;
			14: v = 32'd41722;
			15: v = 32'd20861;
			16: v = 32'd10430;
			17: v = 32'd5215;
			18: v = 32'd2608;
			19: v = 32'd1304;
			20: v = 32'd652;
			21: v = 32'd326;
			22: v = 32'd163;
			23: v = 32'd81;
			24: v = 32'd41;
			25: v = 32'd20;
			26: v = 32'd10;
			27: v = 32'd5;
			28: v = 32'd3;
			29: v = 32'd1;
			30: v = 32'd1;
			default: v = 32'd0;
		endcase
		return v;
	endfunction

	// quarter-turn pre-rotation for vectors in the left half plane
	function automatic vec_t prerot(input dp_t a, input dp_t b);
		vec_t v;
		if (a < 0) begin
			if (b >= 0) begin
				v.x = b;
				v.y = -a;
				v.ang = QUARTER_TURN;
			end else begin
				v.x = -b;
				v.y = a;
				v.ang = -QUARTER_TURN;
			end
		end else begin
			v.x = a;
			v.y = b;
			v.ang = '0;
		end
		return v;
	endfunction

endpackage

@@ rtl/pttb_sqrt_cell.sv @@
// one digit step of the pipelined restoring square root
// depends on pttb_pkg
module pttb_sqrt_cell #(
	parameter int STEP   = 0,
	parameter int SIDE_W = 1
) (
	input  logic                       clk,
	input  logic                       arst_n,
	input  logic                       vld_i,
	input  logic [pttb_pkg::ROOT_W-1:0] rem_i,
	input  logic [pttb_pkg::ROOT_W-1:0] root_i,
	input  logic [SIDE_W-1:0]          side_i,
	output logic                       vld_o,
	output logic [pttb_pkg::ROOT_W-1:0] rem_o,
	output logic [pttb_pkg::ROOT_W-1:0] root_o,
	output logic [SIDE_W-1:0]          side_o
);
	import pttb_pkg::*;

	localparam logic [ROOT_W-1:0] BIT = ROOT_W'(1) << (ROOT_W - 2 - 2 * STEP);

	logic [ROOT_W-1:0] trial;
	logic              fits;
	logic [ROOT_W-1:0] rem_n;
	logic [ROOT_W-1:0] root_n;
	logic              vld_q;
	logic [ROOT_W-1:0] rem_q;
	logic [ROOT_W-1:0] root_q;
	logic [SIDE_W-1:0] side_q;

	always_comb begin
		trial  = root_i + BIT;
		fits   = (rem_i >= trial);
		rem_n  = fits ? (rem_i - trial) : rem_i;
		root_n = fits ? ((root_i >> 1) + BIT) : (root_i >> 1);
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			vld_q <= 1'b0;
		end else begin
			vld_q <= vld_i;
		end
	end

	always_ff @(posedge clk) begin
		rem_q  <= rem_n;
		root_q <= root_n;
		side_q <= side_i;
	end

	assign vld_o  = vld_q;
	assign rem_o  = rem_q;
	assign root_o = root_q;
	assign side_o = side_q;

endmodule

@@ rtl/pttb_cordic_cell.sv @@
// one vectoring micro-rotation for several independent lanes
// depends on pttb_pkg
module pttb_cordic_cell #(
	parameter int STEP   = 0,
	parameter int LANES  = 2,
	parameter int SIDE_W = 1
) (
	input  logic                           clk,
	input  logic                           arst_n,
	input  logic                           vld_i,
	input  pttb_pkg::vec_t [LANES-1:0]     vec_i,
	input  logic [SIDE_W-1:0]              side_i,
	output logic                           vld_o,
	output pttb_pkg::vec_t [LANES-1:0]     vec_o,
	output logic [SIDE_W-1:0]              side_o
);
	import pttb_pkg::*;

	localparam ang_t DELTA = ang_t'({2'b00, atan_turn(STEP)});

	vec_t [LANES-1:0] vec_n;
	vec_t [LANES-1:0] vec_q;
	logic             vld_q;
	logic [SIDE_W-1:0] side_q;

	always_comb begin
		dp_t xs;
		dp_t ys;
		xs = '0;
		ys = '0;
		for (int l = 0; l < LANES; l++) begin
			xs = vec_i[l].x >>> STEP;
			ys = vec_i[l].y >>> STEP;
			if (vec_i[l].y >= 0) begin
				vec_n[l].x   = vec_i[l].x + ys;
				vec_n[l].y   = vec_i[l].y - xs;
				vec_n[l].ang = vec_i[l].ang + DELTA;
			end else begin
				vec_n[l].x   = vec_i[l].x - ys;
				vec_n[l].y   = vec_i[l].y + xs;
				vec_n[l].ang = vec_i[l].ang - DELTA;
			end
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			vld_q <= 1'b0;
		end else begin
			vld_q <= vld_i;
		end
	end

	always_ff @(posedge clk) begin
		vec_q  <= vec_n;
		side_q <= side_i;
	end

	assign vld_o  = vld_q;
	assign vec_o  = vec_q;
	assign side_o = side_q;

endmodule

@@ rtl/position_to_pan_tilt_bytes_unit.sv @@
// top level of the pan/tilt aiming block: squares, root chain, cordic chain, byte scaling
// depends on pttb_pkg, pttb_sqrt_cell, pttb_cordic_cell and the assertion header
`include "position_to_pan_tilt_bytes_unit_assert.svh"

// Turns a target position into pan and tilt DMX bytes for a moving head hung at
// light_height. A transaction is taken whenever start is high; busy is always low,
// so a new position may be given every cycle. The work runs through a fixed
// pipeline: a capture stage, two multiply/sum stages, a row of 32 square-root cells
// (one root bit each), one pre-rotation stage, a row of CORDIC_STAGES rotation cells
// (pan and tilt rotate side by side in each cell) and an output register. The result
// comes out on pan_byte and tilt_byte, marked by done for exactly one cycle. The
// receiver cannot stall: a result that is not taken in its done cycle is gone.
// light_height may only be written while no transaction is in flight.
module position_to_pan_tilt_bytes_unit #(
	parameter int COORD_WIDTH   = pttb_pkg::COORD_WIDTH_DEF,
	parameter int CORDIC_STAGES = pttb_pkg::CORDIC_STAGES_DEF
) (
	input  logic                          clk,
	input  logic                          arst_n,
	input  logic                          start,
	output logic                          busy,
	input  logic signed [COORD_WIDTH-1:0] pos_x,
	input  logic signed [COORD_WIDTH-1:0] pos_y,
	input  logic signed [COORD_WIDTH-1:0] pos_z,
	input  logic                          light_height_we,
	input  logic signed [COORD_WIDTH-1:0] light_height_wdata,
	output logic                          done,
	output logic [7:0]                    pan_byte,
	output logic [7:0]                    tilt_byte
);
	import pttb_pkg::*;

	localparam int W       = COORD_WIDTH;
	localparam int SCALE   = 32 - COORD_WIDTH;     // brings coordinates to 32-bit scale
	localparam int OP_SH   = SCALE + PRE_SHIFT;    // coordinate to cordic operand
	localparam int SIDE_W  = 3 * W + 1;            // x, z, height difference
	localparam int FLAG_W  = 5;

	// flag positions carried along the cordic row
	localparam int F_X_ZERO = 4;
	localparam int F_Z_NEG  = 3;
	localparam int F_R_ZERO = 2;
	localparam int F_D_POS  = 1;
	localparam int F_D_NEG  = 0;

	// configuration register
	logic signed [W-1:0] light_height_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			light_height_q <= W'(LIGHT_HEIGHT_RST);
		end else if (light_height_we) begin
			light_height_q <= light_height_wdata;
		end
	end

	// never stalls
	assign busy = 1'b0;

	// stage 1: capture position, form height difference
	logic                vld_s1;
	logic signed [W-1:0] x_s1;
	logic signed [W-1:0] z_s1;
	logic signed [W:0]   d_s1;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			vld_s1 <= 1'b0;
		end else begin
			vld_s1 <= start && !busy;
		end
	end

	always_ff @(posedge clk) begin
		x_s1 <= pos_x;
		z_s1 <= pos_z;
		d_s1 <= (W+1)'(light_height_q) - (W+1)'(pos_y);
	end

	// stage 2: squares of the magnitudes
	logic [W-1:0]        ux;
	logic [W-1:0]        uz;
	logic                vld_s2;
	logic [2*W-1:0]      xsq_s2;
	logic [2*W-1:0]      zsq_s2;
	logic [SIDE_W-1:0]   side_s2;

	assign ux = x_s1[W-1] ? W'(-x_s1) : W'(x_s1);
	assign uz = z_s1[W-1] ? W'(-z_s1) : W'(z_s1);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			vld_s2 <= 1'b0;
		end else begin
			vld_s2 <= vld_s1;
		end
	end

	always_ff @(posedge clk) begin
		xsq_s2  <= ux * ux;
		zsq_s2  <= uz * uz;
		side_s2 <= {x_s1, z_s1, d_s1};
	end

	// stage 3: sum of squares, scaled to the root's 64-bit range
	logic [2*W:0]        sq_sum;
	logic                vld_s3;
	logic [ROOT_W-1:0]   n_s3;
	logic [SIDE_W-1:0]   side_s3;

	assign sq_sum = {1'b0, xsq_s2} + {1'b0, zsq_s2};

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			vld_s3 <= 1'b0;
		end else begin
			vld_s3 <= vld_s2;
		end
	end

	always_ff @(posedge clk) begin
		n_s3    <= ROOT_W'(sq_sum) << (2 * SCALE);
		side_s3 <= side_s2;
	end

	// square-root row, one root bit per cell
	logic                sq_vld  [ROOT_STEPS+1];
	logic [ROOT_W-1:0]   sq_rem  [ROOT_STEPS+1];
	logic [ROOT_W-1:0]   sq_root [ROOT_STEPS+1];
	logic [SIDE_W-1:0]   sq_side [ROOT_STEPS+1];

	assign sq_vld[0]  = vld_s3;
	assign sq_rem[0]  = n_s3;
	assign sq_root[0] = '0;
	assign sq_side[0] = side_s3;

	for (genvar k = 0; k < ROOT_STEPS; k++) begin : g_root
		pttb_sqrt_cell #(
			.STEP   (k),
			.SIDE_W (SIDE_W)
		) u_cell (
			.clk    (clk),
			.arst_n (arst_n),
			.vld_i  (sq_vld[k]),
			.rem_i  (sq_rem[k]),
			.root_i (sq_root[k]),
			.side_i (sq_side[k]),
			.vld_o  (sq_vld[k+1]),
			.rem_o  (sq_rem[k+1]),
			.root_o (sq_root[k+1]),
			.side_o (sq_side[k+1])
		);
	end

	// pre-rotation stage: build cordic operands, note the degenerate cases
	logic signed [W-1:0] px;
	logic signed [W-1:0] pz;
	logic signed [W:0]   pd;
	logic [31:0]         radius;
	vec_t                pan_pre;
	vec_t                tilt_pre;
	logic                vld_pre;
	vec_t [1:0]          vec_pre;
	logic [FLAG_W-1:0]   flag_pre;

	assign px     = sq_side[ROOT_STEPS][SIDE_W-1 -: W];
	assign pz     = sq_side[ROOT_STEPS][W+W:W+1];
	assign pd     = sq_side[ROOT_STEPS][W:0];
	assign radius = sq_root[ROOT_STEPS][31:0];

	// pan is atan2(x, z), tilt is atan2(d, radius)
	assign pan_pre  = prerot(dp_t'(pz) <<< OP_SH, dp_t'(px) <<< OP_SH);
	assign tilt_pre = prerot(dp_t'({1'b0, radius}) <<< PRE_SHIFT, dp_t'(pd) <<< OP_SH);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			vld_pre <= 1'b0;
		end else begin
			vld_pre <= sq_vld[ROOT_STEPS];
		end
	end

	always_ff @(posedge clk) begin
		vec_pre[0]         <= pan_pre;
		vec_pre[1]         <= tilt_pre;
		flag_pre[F_X_ZERO] <= (px == '0);
		flag_pre[F_Z_NEG]  <= pz[W-1];
		flag_pre[F_R_ZERO] <= (radius == '0);
		flag_pre[F_D_POS]  <= !pd[W] && (pd != '0);
		flag_pre[F_D_NEG]  <= pd[W];
	end

	// cordic row, pan in lane 0 and tilt in lane 1
	logic                cd_vld  [CORDIC_STAGES+1];
	vec_t [1:0]          cd_vec  [CORDIC_STAGES+1];
	logic [FLAG_W-1:0]   cd_flag [CORDIC_STAGES+1];

	assign cd_vld[0]  = vld_pre;
	assign cd_vec[0]  = vec_pre;
	assign cd_flag[0] = flag_pre;

	for (genvar k = 0; k < CORDIC_STAGES; k++) begin : g_cordic
		pttb_cordic_cell #(
			.STEP   (k),
			.LANES  (2),
			.SIDE_W (FLAG_W)
		) u_cell (
			.clk    (clk),
			.arst_n (arst_n),
			.vld_i  (cd_vld[k]),
			.vec_i  (cd_vec[k]),
			.side_i (cd_flag[k]),
			.vld_o  (cd_vld[k+1]),
			.vec_o  (cd_vec[k+1]),
			.side_o (cd_flag[k+1])
		);
	end

	// byte scaling: floor(angle * 255 / 2^32)
	logic [FLAG_W-1:0]   fl;
	logic [31:0]         pan_turn;
	ang_t                tilt_turn;
	logic [39:0]         pan_prod;
	logic signed [41:0]  tilt_prod;
	logic                done_q;
	logic [7:0]          pan_byte_q;
	logic [7:0]          tilt_byte_q;

	assign fl = cd_flag[CORDIC_STAGES];

	always_comb begin
		// x on the axis: straight ahead or straight behind
		if (fl[F_X_ZERO]) begin
			pan_turn = fl[F_Z_NEG] ? 32'h8000_0000 : 32'h0000_0000;
		end else begin
			pan_turn = 32'(-cd_vec[CORDIC_STAGES][0].ang);
		end
		// target directly below or above the light
		if (fl[F_R_ZERO]) begin
			if (fl[F_D_POS]) begin
				tilt_turn = QUARTER_TURN;
			end else if (fl[F_D_NEG]) begin
				tilt_turn = -QUARTER_TURN;
			end else begin
				tilt_turn = '0;
			end
		end else begin
			tilt_turn = cd_vec[CORDIC_STAGES][1].ang;
		end
		pan_prod  = {pan_turn, 8'h00} - {8'h00, pan_turn};
		tilt_prod = (42'(tilt_turn) <<< 8) - 42'(tilt_turn);
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			done_q <= 1'b0;
		end else begin
			done_q <= cd_vld[CORDIC_STAGES];
		end
	end

	always_ff @(posedge clk) begin
		pan_byte_q  <= pan_prod[39:32];
		tilt_byte_q <= tilt_prod[39:32];
	end

	assign done      = done_q;
	assign pan_byte  = pan_byte_q;
	assign tilt_byte = tilt_byte_q;

	// a taken transaction enters the first stage
	`PTTB_ASSERT_NEXT(a_start_enters, start && !busy, vld_s1)
	// every result leaves the last rotation cell the cycle before it shows on done
	`PTTB_ASSERT_NEXT(a_done_from_row, cd_vld[CORDIC_STAGES], done)
	// pan is wrapped into one turn, so the top code never shows
	`PTTB_ASSERT_IMPL(a_pan_wrapped, done, pan_byte != 8'hFF)
	// a transaction that leaves the root row always enters the cordic row
	`PTTB_ASSERT_NEXT(a_root_to_cordic, sq_vld[ROOT_STEPS], cd_vld[0])

endmodule

@@ verif/tb_top.sv @@
`timescale 1ns / 100ps
// testbench for position_to_pan_tilt_bytes_unit: random and corner positions under several heights
// depends on pttb_pkg and the rtl of the block; the expected bytes come from an in-bench cordic
module tb_top;
	localparam int CW = pttb_pkg::COORD_WIDTH_DEF;
	localparam int STAGES = pttb_pkg::CORDIC_STAGES_DEF;
	localparam int UP_SHIFT = 32 - CW;
	localparam int LATENCY = 37 + STAGES;
	localparam longint QTR = longint'(1) <<< 30;
	localparam longint HALF = longint'(1) <<< 31;

	typedef struct {
		logic signed [CW-1:0] x;
		logic signed [CW-1:0] y;
		logic signed [CW-1:0] z;
	} position_t;

	typedef struct {
		logic [7:0] pan;
		logic [7:0] tilt;
	} aim_t;

	logic clk = 1'b0;
	logic arst_n = 1'b0;
	logic start = 1'b0;
	logic busy;
	logic signed [CW-1:0] pos_x = '0;
	logic signed [CW-1:0] pos_y = '0;
	logic signed [CW-1:0] pos_z = '0;
	logic light_height_we = 1'b0;
	logic signed [CW-1:0] light_height_wdata = '0;
	logic done;
	logic [7:0] pan_byte;
	logic [7:0] tilt_byte;

	position_t positions_to_send[$];
	aim_t aims_due[$];
	logic signed [CW-1:0] height_now;
	int errors = 0;
	int sent = 0;
	int seen = 0;
	int heights_used = 0;
	int gap_left = 0;
	int burst_left = 0;

	position_to_pan_tilt_bytes_unit #(.COORD_WIDTH(CW), .CORDIC_STAGES(STAGES)) uut (
		.clk(clk), .arst_n(arst_n), .start(start), .busy(busy),
		.pos_x(pos_x), .pos_y(pos_y), .pos_z(pos_z),
		.light_height_we(light_height_we), .light_height_wdata(light_height_wdata),
		.done(done), .pan_byte(pan_byte), .tilt_byte(tilt_byte)
	);

	always begin
		#2 clk = 1'b1;
		#2 clk = 1'b0;
	end

	// atan table in 2^-32 turn per stage
	function automatic longint atan_step(input int i);
		longint tbl[0:31] = '{536870912, 316933406, 167458907, 85004756, 42667331,
			21354465, 10679838, 5340245, 2670163, 1335087, 667544, 333772, 166886,
			83443, 41722, 20861, 10430, 5215, 2608, 1304, 652, 326, 163, 81, 41, 20,
			10, 5, 3, 1, 1, 0};
		return tbl[i];
	endfunction

	// bitwise integer square root, floor
	function automatic longint unsigned int_sqrt(input longint unsigned n);
		longint unsigned root = 0;
		longint unsigned bitv = longint'(1) <<< 62;
		while (bitv > n)
			bitv = bitv >> 2;
		while (bitv != 0) begin
			if (n >= root + bitv) begin
				n = n - (root + bitv);
				root = (root >> 1) + bitv;
			end else begin
				root = root >> 1;
			end
			bitv = bitv >> 2;
		end
		return root;
	endfunction

	// vectoring cordic: angle of (a, b) in 2^-32 turn
	function automatic longint vector_angle(input longint b, input longint a);
		longint vx = a <<< 24;
		longint vy = b <<< 24;
		longint ang = 0;
		longint t, sx, sy;
		if (vx < 0) begin
			t = vx;
			if (vy >= 0) begin
				vx = vy;
				vy = -t;
				ang = QTR;
			end else begin
				vx = -vy;
				vy = t;
				ang = -QTR;
			end
		end
		for (int i = 0; i < STAGES && i < 32; i++) begin
			sx = vx >>> i;
			sy = vy >>> i;
			if (vy >= 0) begin
				vx = vx + sy;
				vy = vy - sx;
				ang = ang + atan_step(i);
			end else begin
				vx = vx - sy;
				vy = vy + sx;
				ang = ang - atan_step(i);
			end
		end
		return ang;
	endfunction

	function automatic aim_t aim_for(input position_t p, input logic signed [CW-1:0] h);
		longint x = longint'(p.x);
		longint y = longint'(p.y);
		longint z = longint'(p.z);
		longint ux = (x < 0) ? -x : x;
		longint uz = (z < 0) ? -z : z;
		longint unsigned sum;
		longint r, d, tilt, scaled;
		longint unsigned pan;
		aim_t res;
		sum = longint'(ux * ux + uz * uz);
		r = longint'(int_sqrt(sum << (2 * UP_SHIFT)));
		d = (longint'(h) - y) <<< UP_SHIFT;
		if (x == 0)
			pan = (z < 0) ? HALF : 0;
		else
			pan = (64'd0 - longint'(vector_angle(x <<< UP_SHIFT, z <<< UP_SHIFT)))
				& 64'hFFFF_FFFF;
		// straight above or below: tilt is a plain quarter turn
		if (r == 0)
			tilt = (d > 0) ? QTR : ((d < 0) ? -QTR : 0);
		else
			tilt = vector_angle(d, r);
		res.pan = 8'((pan * 255) >> 32);
		scaled = (tilt * 255) >>> 32;
		res.tilt = scaled[7:0];
		return res;
	endfunction

	// driver: bursts of items with random gaps between them
	always @(posedge clk) begin
		if (start && !busy) begin
			aims_due.push_back(aim_for('{pos_x, pos_y, pos_z}, height_now));
			sent++;
		end
		if (start && busy) begin
			// hold the transaction until it is taken
		end else if (gap_left > 0) begin
			gap_left--;
			start <= 1'b0;
		end else if (positions_to_send.size() > 0) begin
			position_t p;
			p = positions_to_send.pop_front();
			pos_x <= p.x;
			pos_y <= p.y;
			pos_z <= p.z;
			start <= 1'b1;
			if (burst_left > 0) begin
				burst_left--;
			end else begin
				burst_left = $urandom_range(0, 12);
				// some stretches run back to back
				gap_left = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 6);
			end
		end else begin
			start <= 1'b0;
		end
	end

	// monitor: every done cycle carries one result
	always @(posedge clk) begin
		if (arst_n && done) begin
			aim_t e;
			seen++;
			if (aims_due.size() == 0) begin
				$error("result with nothing expected: pan %0d tilt %0d", pan_byte, tilt_byte);
				errors++;
			end else begin
				e = aims_due.pop_front();
				if (pan_byte !== e.pan) begin
					$error("pan_byte expected %0d actual %0d", e.pan, pan_byte);
					errors++;
				end
				if (tilt_byte !== e.tilt) begin
					$error("tilt_byte expected %0d actual %0d", e.tilt, tilt_byte);
					errors++;
				end
			end
		end
	end

	function automatic logic signed [CW-1:0] rand_coord();
		case ($urandom_range(0, 5))
			0: return CW'($urandom);
			1: return CW'($urandom_range(0, 40)) - CW'(20);
			2: return '0;
			3: return ($urandom_range(0, 1)) ? {1'b0, {(CW-1){1'b1}}} : {1'b1, {(CW-1){1'b0}}};
			default: return CW'($urandom_range(0, 2 * 655360)) - CW'(655360);
		endcase
	endfunction

	task automatic add_pos(input logic signed [CW-1:0] x, input logic signed [CW-1:0] y,
		input logic signed [CW-1:0] z);
		positions_to_send.push_back('{x, y, z});
	endtask

	task automatic wait_idle();
		while (positions_to_send.size() > 0 || start || aims_due.size() > 0)
			@(posedge clk);
		repeat (4) @(posedge clk);
	endtask

	task automatic write_height(input logic signed [CW-1:0] h);
		@(posedge clk);
		light_height_we <= 1'b1;
		light_height_wdata <= h;
		height_now = h;
		@(posedge clk);
		light_height_we <= 1'b0;
		heights_used++;
	endtask

	initial begin
		logic signed [CW-1:0] mx, mn;
		logic signed [CW-1:0] heights[4];
		mx = {1'b0, {(CW-1){1'b1}}};
		mn = {1'b1, {(CW-1){1'b0}}};
		height_now = CW'(pttb_pkg::LIGHT_HEIGHT_RST);
		repeat (8) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);
		// directed: extremes, axis cases, target straight below/above/level
		add_pos(0, 0, 0);
		add_pos(0, 0, 65536);
		add_pos(0, 0, -65536);
		add_pos(0, 0, mn);
		add_pos(0, 0, mx);
		add_pos(65536, 0, 0);
		add_pos(-65536, 0, 0);
		add_pos(mx, mx, mx);
		add_pos(mn, mn, mn);
		add_pos(mx, mn, mn);
		add_pos(mn, mx, mx);
		add_pos(0, height_now, 0);
		add_pos(0, CW'(height_now + CW'(1)), 0);
		add_pos(0, CW'(height_now - CW'(1)), 0);
		add_pos(-1, 0, 1);
		add_pos(1, 0, -1);
		add_pos(-1, 0, -1);
		add_pos(-1, -1, 0);
		add_pos(1, 1, 0);
		add_pos(12345, -54321, -98765);
		for (int i = 0; i < 180; i++)
			add_pos(rand_coord(), rand_coord(), rand_coord());
		wait_idle();
		heights[0] = mx;
		heights[1] = mn;
		heights[2] = '0;
		heights[3] = CW'($urandom);
		foreach (heights[k]) begin
			write_height(heights[k]);
			add_pos(0, heights[k], 0);
			add_pos(0, 0, 0);
			for (int i = 0; i < 200; i++)
				add_pos(rand_coord(), rand_coord(), rand_coord());
			wait_idle();
		end
		repeat (LATENCY + 10) @(posedge clk);
		$display("sent %0d positions, checked %0d results over %0d written heights",
			sent, seen, heights_used);
		if (errors == 0 && aims_due.size() == 0) begin
			$display("simulation ok");
		end else begin
			$display("simulation failed");
		end
		$finish;
	end

	initial begin
		#2000000;
		$display("simulation failed");
		$finish;
	end
endmodule
